>>> hdl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// shared types, constants and round functions of the tea block decrypter
// ----------------------------------------------------------------------------
package tea_pkg;

   localparam int unsigned ROUNDS = 32;
   localparam int unsigned STAGES = 2 * ROUNDS;

   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD0_IDX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD1_IDX = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD2_IDX = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] KEY_WORD3_IDX = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type v0;
      word_type v1;
      logic     last;
   } blk_type;

   // running sum at the start of round r, counted from zero
   function automatic word_type round_sum(input int unsigned r);
      logic [2*WORD_W-1:0] prod;
      prod = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(ROUNDS - r);
      return prod[WORD_W-1:0];
   endfunction

   function automatic word_type tea_mix(input word_type v, input word_type sum,
                                        input word_type ka, input word_type kb);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
   endfunction

endpackage

>>> hdl/tea_half_round.sv
// ----------------------------------------------------------------------------
// tea_half_round
// one registered half-round: subtracts the mixed other word from one word
// ----------------------------------------------------------------------------
module tea_half_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  tea_pkg::blk_type  in_blk,
   input  tea_pkg::word_type sum,
   input  tea_pkg::word_type key_a,
   input  tea_pkg::word_type key_b,
   input  logic              upd_first,
   output logic              out_valid,
   output tea_pkg::blk_type  out_blk
);

   logic             valid_ff;
   tea_pkg::blk_type blk_ff;
   tea_pkg::blk_type blk_in;

   // upd_first: first word takes the mix of the second, else the reverse
   always_comb begin
      blk_in = in_blk;
      if (upd_first) begin
         blk_in.v0 = in_blk.v0 - tea_pkg::tea_mix(in_blk.v1, sum, key_a, key_b);
      end else begin
         blk_in.v1 = in_blk.v1 - tea_pkg::tea_mix(in_blk.v0, sum, key_a, key_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

>>> hdl/tea_out_buf.sv
// ----------------------------------------------------------------------------
// tea_out_buf
// output register with a one-entry skid stage; freezes the pipeline when full
// ----------------------------------------------------------------------------
module tea_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  tea_pkg::blk_type in_blk,
   output logic             advance,
   output logic             out_valid,
   output tea_pkg::blk_type out_blk,
   input  logic             out_stall
);

   logic             out_valid_ff;
   logic             skid_valid_ff;
   tea_pkg::blk_type out_blk_ff;
   tea_pkg::blk_type skid_blk_ff;
   logic             arrive;
   logic             out_free;

   assign advance  = !skid_valid_ff;
   assign arrive   = advance && in_valid;
   assign out_free = !out_valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || arrive;
         skid_valid_ff <= 1'b0;
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_blk_ff <= skid_valid_ff ? skid_blk_ff : in_blk;
      end
      if (!out_free && arrive) begin
         skid_blk_ff <= in_blk;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_blk   = out_blk_ff;

   // skid only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item with no result waiting");

   // a waiting result is never dropped
   a_out_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stall) |=> out_valid_ff)
      else $error("stalled result lost");

   // a full skid drains into the output as soon as it frees
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid did not drain");

endmodule

>>> hdl/tea_block_decrypt.sv
// ----------------------------------------------------------------------------
// tea_block_decrypt
// tea decryption of 64-bit blocks under a 128-bit key, one half-round a stage
// ----------------------------------------------------------------------------
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  request  | req_valid, req_stall, req_cipher_first/second,| in
//           | req_block_last                                |
//  response | rsp_valid, rsp_stall, rsp_plain_first/second, | out
//           | rsp_result_last                               |
//  csr      | csr_write_enable, csr_index, csr_data         | in
//
// one block enters per cycle while req_stall is low; the path runs through one
// pipeline stage per half-round plus the output register
// reset clears all stage valid bits and the key words; no clearing pass
// a stalled response first fills a one-entry skid, after which req_stall rises
// and the whole round pipeline holds until the skid drains
// ----------------------------------------------------------------------------
module tea_block_decrypt (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [31:0]                         req_cipher_first,
   input  logic [31:0]                         req_cipher_second,
   input  logic                                req_block_last,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_plain_first,
   output logic [31:0]                         rsp_plain_second,
   output logic                                rsp_result_last,
   // key registers
   input  logic                                csr_write_enable,
   input  logic [tea_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_data
);

   // key words; the user must write them only while idle, the block does not enforce it
   tea_pkg::word_type key0_ff, key1_ff, key2_ff, key3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tea_pkg::KEY_WORD0_IDX: key0_ff <= csr_data;
            tea_pkg::KEY_WORD1_IDX: key1_ff <= csr_data;
            tea_pkg::KEY_WORD2_IDX: key2_ff <= csr_data;
            tea_pkg::KEY_WORD3_IDX: key3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance from the output buffer: low only while its skid is full
   logic             advance;
   logic             stage_valid [0:tea_pkg::STAGES];
   tea_pkg::blk_type stage_blk   [0:tea_pkg::STAGES];
   tea_pkg::blk_type rsp_blk;

   assign req_stall = !advance;

   // stage 0 is the raw request; a transfer loads the first half-round
   assign stage_valid[0]   = req_valid;
   assign stage_blk[0].v0   = req_cipher_first;
   assign stage_blk[0].v1   = req_cipher_second;
   assign stage_blk[0].last = req_block_last;

   // even stages: second word from k2/k3, odd stages: first word from k0/k1
   for (genvar g = 0; g < tea_pkg::STAGES; g++) begin : g_stage
      localparam tea_pkg::word_type SUM_G = tea_pkg::round_sum(g / 2);
      localparam logic UPD_FIRST_G = (g % 2) == 1;

      tea_half_round u_half (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[g]),
         .in_blk    (stage_blk[g]),
         .sum       (SUM_G),
         .key_a     (UPD_FIRST_G ? key0_ff : key2_ff),
         .key_b     (UPD_FIRST_G ? key1_ff : key3_ff),
         .upd_first (UPD_FIRST_G),
         .out_valid (stage_valid[g+1]),
         .out_blk   (stage_blk[g+1])
      );
   end

   // output register and skid parting the pipeline from the response side
   tea_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[tea_pkg::STAGES]),
      .in_blk    (stage_blk[tea_pkg::STAGES]),
      .advance   (advance),
      .out_valid (rsp_valid),
      .out_blk   (rsp_blk),
      .out_stall (rsp_stall)
   );

   assign rsp_plain_first  = rsp_blk.v0;
   assign rsp_plain_second = rsp_blk.v1;
   assign rsp_result_last  = rsp_blk.last;

endmodule

>>> test/tea_decrypt_checker.sv
// ----------------------------------------------------------------------------
// tea_decrypt_checker
// watches the key port and both channels of the tea block decrypter, works
// out the plaintext of every accepted ciphertext block under its own copy of
// the key and compares each response transfer with the oldest prediction
// ----------------------------------------------------------------------------
module tea_decrypt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [31:0]                     req_cipher_first,
   input  logic [31:0]                     req_cipher_second,
   input  logic                            req_block_last,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [31:0]                     rsp_plain_first,
   input  logic [31:0]                     rsp_plain_second,
   input  logic                            rsp_result_last,
   input  logic                            csr_write_enable,
   input  logic [tea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data,
   output int                              fail_count,
   output int                              pending_count
);

   typedef struct packed {
      tea_pkg::word_type first;
      tea_pkg::word_type second;
      logic              last;
   } plain_block_type;

   tea_pkg::word_type key_word [4];
   plain_block_type   plain_fifo [$];

   function automatic tea_pkg::word_type feistel_term(input tea_pkg::word_type w,
                                                      input tea_pkg::word_type sum,
                                                      input tea_pkg::word_type ka,
                                                      input tea_pkg::word_type kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

   // 32 rounds run backwards, sum starting at delta times the round count
   function automatic plain_block_type decipher_block(input tea_pkg::word_type c_first,
                                                      input tea_pkg::word_type c_second,
                                                      input logic last);
      tea_pkg::word_type v0;
      tea_pkg::word_type v1;
      tea_pkg::word_type sum;
      plain_block_type   result;
      v0  = c_first;
      v1  = c_second;
      sum = tea_pkg::word_type'(tea_pkg::TEA_DELTA * tea_pkg::ROUNDS);
      for (int unsigned r = 0; r < tea_pkg::ROUNDS; r++) begin
         v1  = v1 - feistel_term(v0, sum, key_word[2], key_word[3]);
         v0  = v0 - feistel_term(v1, sum, key_word[0], key_word[1]);
         sum = sum - tea_pkg::TEA_DELTA;
      end
      result.first  = v0;
      result.second = v1;
      result.last   = last;
      return result;
   endfunction

   always @(posedge clock) begin : observe
      plain_block_type want;
      if (reset) begin
         foreach (key_word[i]) key_word[i] = '0;
         plain_fifo.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               tea_pkg::KEY_WORD0_IDX: key_word[0] = csr_data;
               tea_pkg::KEY_WORD1_IDX: key_word[1] = csr_data;
               tea_pkg::KEY_WORD2_IDX: key_word[2] = csr_data;
               tea_pkg::KEY_WORD3_IDX: key_word[3] = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (plain_fifo.size() == 0) begin
               $display("%0t: response with nothing outstanding, got %h %h %b", $time,
                        rsp_plain_first, rsp_plain_second, rsp_result_last);
               fail_count++;
            end else begin
               want = plain_fifo.pop_front();
               if (rsp_plain_first !== want.first) begin
                  $display("%0t: plain_first expected %h, got %h", $time,
                           want.first, rsp_plain_first);
                  fail_count++;
               end
               if (rsp_plain_second !== want.second) begin
                  $display("%0t: plain_second expected %h, got %h", $time,
                           want.second, rsp_plain_second);
                  fail_count++;
               end
               if (rsp_result_last !== want.last) begin
                  $display("%0t: result_last expected %b, got %b", $time,
                           want.last, rsp_result_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            plain_fifo.push_back(decipher_block(req_cipher_first, req_cipher_second,
                                                req_block_last));
         pending_count = plain_fifo.size();
      end
   end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// regression of the tea block decrypter: directed extreme blocks, then
// random buffers of blocks under a series of keys, with bursty requests and
// a patterned response stall; checking is done by tea_decrypt_checker
// ----------------------------------------------------------------------------
module testbench;

   // cycles with no transfer and no key write before the run is abandoned
   localparam int IDLE_LIMIT   = 5000;
   // pipeline depth plus a margin, waited out after the last response
   localparam int DRAIN_CYCLES = tea_pkg::STAGES + 16;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [31:0]                     req_cipher_first = '0;
   logic [31:0]                     req_cipher_second = '0;
   logic                            req_block_last = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [31:0]                     rsp_plain_first;
   logic [31:0]                     rsp_plain_second;
   logic                            rsp_result_last;
   logic                            csr_write_enable = 1'b0;
   logic [tea_pkg::CSR_INDEX_W-1:0] csr_index = tea_pkg::KEY_WORD0_IDX;
   logic [31:0]                     csr_data = '0;

   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   int burst_left  = 0;
   int buffer_left = 0;
   int stall_left  = 0;
   int stall_mode  = 0;

   always #5 clock = ~clock;

   tea_block_decrypt u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cipher_first  (req_cipher_first),
      .req_cipher_second (req_cipher_second),
      .req_block_last    (req_block_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_plain_first   (rsp_plain_first),
      .rsp_plain_second  (rsp_plain_second),
      .rsp_result_last   (rsp_result_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   tea_decrypt_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cipher_first  (req_cipher_first),
      .req_cipher_second (req_cipher_second),
      .req_block_last    (req_block_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_plain_first   (rsp_plain_first),
      .rsp_plain_second  (rsp_plain_second),
      .rsp_result_last   (rsp_result_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // receiver stall: segments of random length, each with its own behaviour
   // (never stalling, coin toss, mostly stalled, or stalled solid)
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(4, 60);
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b1;
      endcase
      stall_left--;
   end

   // watchdog: any transfer or key write counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tea_block_decrypt regression: fail");
         $finish;
      end
   end

   // mostly random words, with a share of all-zero, all-one, single-bit-set and single-bit-clear values
   function automatic tea_pkg::word_type random_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return tea_pkg::word_type'(1) << $urandom_range(0, 31);
         3:       return ~(tea_pkg::word_type'(1) << $urandom_range(0, 31));
         default: return $urandom();
      endcase
   endfunction

   // one request transfer; valid stays high across a burst and drops for the gap
   task automatic send_block(input tea_pkg::word_type first,
                             input tea_pkg::word_type second,
                             input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_cipher_first  <= first;
      req_cipher_second <= second;
      req_block_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // stop requesting and wait until every predicted block has come back
   task automatic end_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_key_word(input logic [tea_pkg::CSR_INDEX_W-1:0] idx,
                                 input tea_pkg::word_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
   endtask

   // key changes only once the pipeline is empty
   task automatic load_key(input tea_pkg::word_type k0, input tea_pkg::word_type k1,
                           input tea_pkg::word_type k2, input tea_pkg::word_type k3);
      end_phase();
      write_key_word(tea_pkg::KEY_WORD0_IDX, k0);
      write_key_word(tea_pkg::KEY_WORD1_IDX, k1);
      write_key_word(tea_pkg::KEY_WORD2_IDX, k2);
      write_key_word(tea_pkg::KEY_WORD3_IDX, k3);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // word extremes, alternating patterns, lone top and bottom bits, both flag values,
   // and the ciphertext of an all-zero block under the all-zero key
   task automatic run_directed();
      send_block(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      send_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      send_block(32'h8000_0000, 32'h0000_0001, 1'b0);
      send_block(32'h0000_0001, 32'h8000_0000, 1'b1);
      send_block(32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0);
      send_block(32'h41EA_3A0A, 32'h94BA_A940, 1'b1);
      send_block(32'h0000_001F, 32'h0000_0010, 1'b1);
   endtask

   // random buffers: runs of blocks closed by a last flag, with some stray flags
   task automatic run_random(input int count);
      logic last;
      repeat (count) begin
         if (buffer_left == 0)
            buffer_left = $urandom_range(1, 8);
         last = (buffer_left == 1);
         if ($urandom_range(0, 9) == 0)
            last = 1'($urandom_range(0, 1));
         send_block(random_word(), random_word(), last);
         buffer_left--;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset key first, then the all-one key
      run_directed();
      load_key('1, '1, '1, '1);
      run_directed();
      run_random(60);

      load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      run_random(100);

      // each half-round mixes under a zero first key word and an all-one second key word
      load_key('0, '1, '0, '1);
      run_random(80);

      repeat (7) begin
         load_key(random_word(), random_word(), random_word(), random_word());
         run_random(100);
      end

      // back to zero by explicit writes
      load_key('0, '0, '0, '0);
      run_random(60);

      end_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tea_block_decrypt regression: pass");
      else
         $display("tea_block_decrypt regression: fail");
      $finish;
   end

endmodule
